### sv/ppsch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppsch_pkg;

  // Input operation codes carried on in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // One process table entry, stored as a single memory word.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

  // Running result of one table scan.
  typedef struct packed {
    logic       found;
    entry_t     best;
    logic       cur_hit;
    entry_t     cur;
    logic [1:0] busy_cnt;
  } scan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### sv/ppsch_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ppsch_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/ppsch_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module ppsch_scan #(
  parameter int IW = 4
) (
  input  wire logic              clk,
  input  wire logic              clr,
  input  wire logic              ent_vld,
  input  wire ppsch_pkg::entry_t ent,
  input  wire logic [IW-1:0]     ent_k,
  input  wire logic [15:0]       now_tick,
  input  wire logic [IW-1:0]     cur_slot,
  input  wire logic              cur_valid,
  output ppsch_pkg::scan_t       res,
  output logic      [IW-1:0]     best_k
);
  import ppsch_pkg::*;

  scan_t         res_r;
  logic [IW-1:0] best_k_r;
  logic          ready;
  logic          better;

  // Shared compare unit: one entry is judged per cycle.
  assign ready  = (ent.remaining != 16'd0) && (ent.arrival <= now_tick);
  assign better = ready && (!res_r.found || (ent.prio < res_r.best.prio));

  always_ff @(posedge clk) begin
    if (clr) begin
      res_r.found    <= 1'b0;
      res_r.cur_hit  <= 1'b0;
      res_r.busy_cnt <= 2'd0;
    end else if (ent_vld) begin
      if (better) begin
        res_r.found <= 1'b1;
        res_r.best  <= ent;
        best_k_r    <= ent_k;
      end
      if (ready && cur_valid && (ent_k == cur_slot)) begin
        res_r.cur_hit <= 1'b1;
        res_r.cur     <= ent;
      end
      // Count entries with work left, saturating at two.
      if ((ent.remaining != 16'd0) && (res_r.busy_cnt != 2'd2)) begin
        res_r.busy_cnt <= res_r.busy_cnt + 2'd1;
      end
    end
  end

  assign res    = res_r;
  assign best_k = best_k_r;

endmodule

`default_nettype wire

### sv/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// A load transfer produces no result.
// A tick transfer reads the process table from its single read port, one entry per cycle,
// then passes ST_DRAIN and ST_DECIDE and registers its report in ST_FINISH once the output is free.
// The empty table skips ST_SCAN and ST_DRAIN and goes straight to ST_DECIDE.
// One item is in work at a time; a new item is taken once the previous one has finished.
// Synchronous active-low reset empties the table, clears time and the running process.

module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // proc_id[7:0], arrival_time[23:8], burst_length[39:24], prio_level[47:40]
  input  wire logic [47:0] in_tdata,
  // op[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // idle[0], running_id[8:1], finished[9], turnaround[25:10], waiting[41:26],
  // all_done[42], zero[47:43]
  output logic      [47:0] out_tdata
);
  import ppsch_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_PROCS);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] issue_k_r;
  logic          pend_r;
  logic [IW-1:0] pend_k_r;
  logic [15:0]   now_r;
  logic [IW-1:0] cur_slot_r;
  logic          cur_valid_r;
  logic          out_valid_r;
  logic [47:0]   out_data_r;

  entry_t        pk_r;
  logic [IW-1:0] pk_k_r;
  logic          pk_found_r;
  logic          done_r;

  logic          in_acc;
  logic          out_free;
  logic          scan_clr;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  entry_t        load_ent;
  scan_t         scan;
  logic [IW-1:0] best_k;
  logic          keep_cur;
  logic [16:0]   tat_full;
  logic [15:0]   tat;
  logic [15:0]   wt;
  logic          fin;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign load_ent.id        = in_tdata[7:0];
  assign load_ent.arrival   = in_tdata[23:8];
  assign load_ent.burst     = in_tdata[39:24];
  assign load_ent.remaining = in_tdata[39:24];
  assign load_ent.prio      = in_tdata[47:40];

  // Sequencer: next state and memory controls.
  always_comb begin
    state_nxt = state_r;
    scan_clr  = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pk_k_r;
    wr_data   = pk_r;
    wr_data.remaining = pk_r.remaining - 16'd1;
    unique case (state_r)
      ST_IDLE: begin
        wr_addr = count_r[IW-1:0];
        wr_data = load_ent;
        if (in_acc) begin
          if (in_tuser == OP_LOAD) begin
            wr_en = (count_r != FULL);
          end else begin
            scan_clr  = 1'b1;
            state_nxt = (count_r == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (issue_k_r == count_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          wr_en     = pk_found_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  ppsch_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (issue_k_r[IW-1:0]),
    .rdata (rd_data)
  );

  ppsch_scan #(
    .IW (IW)
  ) u_scan (
    .clk       (clk),
    .clr       (scan_clr),
    .ent_vld   (pend_r),
    .ent       (rd_data),
    .ent_k     (pend_k_r),
    .now_tick  (now_r),
    .cur_slot  (cur_slot_r),
    .cur_valid (cur_valid_r),
    .res       (scan),
    .best_k    (best_k)
  );

  // Read address counter and the tag of the word arriving next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= rd_en;
    end
    pend_k_r <= issue_k_r[IW-1:0];
    if (scan_clr) begin
      issue_k_r <= '0;
    end else if (rd_en) begin
      issue_k_r <= issue_k_r + CW'(1);
    end
  end

  // On a tie the process that ran last keeps the processor.
  assign keep_cur = scan.found && scan.cur_hit && (scan.cur.prio == scan.best.prio);

  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE) begin
      pk_found_r <= scan.found;
      pk_r       <= keep_cur ? scan.cur : scan.best;
      pk_k_r     <= keep_cur ? cur_slot_r : best_k;
      done_r     <= (scan.busy_cnt == 2'd0) ||
                    ((scan.busy_cnt == 2'd1) && scan.found &&
                     ((keep_cur ? scan.cur.remaining : scan.best.remaining) == 16'd1));
    end
  end

  // Turnaround and waiting times, both saturating.
  assign fin      = pk_found_r && (pk_r.remaining == 16'd1);
  assign tat_full = {1'b0, now_r} + 17'd1 - {1'b0, pk_r.arrival};
  assign tat      = tat_full[16] ? 16'hFFFF : tat_full[15:0];
  assign wt       = (tat >= pk_r.burst) ? (tat - pk_r.burst) : 16'd0;

  // Table count, time, running process and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      now_r       <= 16'd0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && (in_tuser == OP_LOAD) && (count_r != FULL)) begin
        count_r <= count_r + CW'(1);
      end
      if ((state_r == ST_FINISH) && out_free) begin
        cur_valid_r <= pk_found_r;
        if (pk_found_r) begin
          cur_slot_r <= pk_k_r;
        end
        if (now_r != 16'hFFFF) begin
          now_r <= now_r + 16'd1;
        end
      end
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_data_r <= {5'd0, done_r,
                     fin ? wt : 16'd0,
                     fin ? tat : 16'd0,
                     fin,
                     pk_found_r ? pk_r.id : 8'd0,
                     !pk_found_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ppsch_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 400;
  // Table entries used by the early tests and random traffic; the rest are kept for the end.
  localparam int EARLY_SLOTS = 12;

  // One tick report, as the block packs it on out_tdata.
  typedef struct packed {
    logic        all_done;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic        finished;
    logic [7:0]  running_id;
    logic        idle;
  } tick_report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  // Predicted process table and scheduler state.
  entry_t      proc_tbl [TABLE_DEPTH];
  int          tbl_count = 0;
  logic [15:0] sim_now = '0;
  int          last_slot = 0;
  bit          last_valid = 1'b0;

  tick_report_t expected_reports [$];

  // Run control shared between the stimulus and the result side.
  bit          no_gaps = 1'b0;
  bit          stall_req = 1'b0;
  int          hold_left = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          n_loads = 0;
  int          n_ticks = 0;
  int          n_reports = 0;
  int          n_finished = 0;
  int          n_idle = 0;

  preemptive_priority_scheduler #(
    .MAX_PROCS(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit in case the block hangs.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("preemptive_priority_scheduler test failed");
    $finish;
  end

  // A slot competes when it has work left and has arrived.
  function automatic bit slot_ready(int k);
    return proc_tbl[k].remaining != 16'd0 && proc_tbl[k].arrival <= sim_now;
  endfunction

  // Append one process to the predicted table; a full table drops it.
  function automatic void load_entry(logic [47:0] d);
    if (tbl_count < TABLE_DEPTH) begin
      proc_tbl[tbl_count].id        = d[7:0];
      proc_tbl[tbl_count].arrival   = d[23:8];
      proc_tbl[tbl_count].burst     = d[39:24];
      proc_tbl[tbl_count].remaining = d[39:24];
      proc_tbl[tbl_count].prio      = d[47:40];
      tbl_count++;
    end
  endfunction

  // Pick and serve one process for a tick, then advance time.
  function automatic tick_report_t schedule_tick();
    tick_report_t r;
    int           pick;
    bit           found;
    logic [16:0]  tat;
    r     = '0;
    pick  = 0;
    found = 1'b0;
    for (int k = 0; k < tbl_count; k++) begin
      if (slot_ready(k) && (!found || proc_tbl[k].prio < proc_tbl[pick].prio)) begin
        pick  = k;
        found = 1'b1;
      end
    end
    // On equal priority the process that just ran keeps the processor.
    if (found && last_valid && last_slot < tbl_count && slot_ready(last_slot) &&
        proc_tbl[last_slot].prio == proc_tbl[pick].prio) begin
      pick = last_slot;
    end
    if (found) begin
      proc_tbl[pick].remaining = proc_tbl[pick].remaining - 16'd1;
      r.running_id = proc_tbl[pick].id;
      if (proc_tbl[pick].remaining == 16'd0) begin
        r.finished   = 1'b1;
        tat          = {1'b0, sim_now} + 17'd1 - {1'b0, proc_tbl[pick].arrival};
        r.turnaround = (tat > 17'h0FFFF) ? 16'hFFFF : tat[15:0];
        r.waiting    = (r.turnaround >= proc_tbl[pick].burst) ?
                       r.turnaround - proc_tbl[pick].burst : 16'd0;
      end
      last_slot  = pick;
      last_valid = 1'b1;
    end else begin
      r.idle     = 1'b1;
      last_valid = 1'b0;
    end
    r.all_done = 1'b1;
    for (int k = 0; k < tbl_count; k++) begin
      if (proc_tbl[k].remaining != 16'd0) r.all_done = 1'b0;
    end
    if (sim_now != 16'hFFFF) sim_now = sim_now + 16'd1;
    return r;
  endfunction

  // Offer one item and wait for its transfer; then predict its effect.
  task automatic send_item(input logic op, input logic [47:0] data);
    if (!no_gaps && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      load_entry(data);
      n_loads++;
    end else begin
      expected_reports.push_back(schedule_tick());
      n_ticks++;
    end
  endtask

  task automatic load_proc(input logic [7:0] id, input logic [15:0] arrival,
                           input logic [15:0] burst, input logic [7:0] prio);
    send_item(OP_LOAD, {prio, burst, arrival, id});
  endtask

  // Ticks carry random content in the unused data bits.
  task automatic send_ticks(input int n);
    logic [63:0] noise;
    for (int i = 0; i < n; i++) begin
      noise = {$urandom(), $urandom()};
      send_item(OP_TICK, noise[47:0]);
    end
  endtask

  // Stop offering and wait until every predicted report has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Result side: check each transfer, then choose the next ready level.
  always @(posedge clk) begin
    tick_report_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      n_reports++;
      if (expected_reports.size() == 0) begin
        $error("report transfer with no tick waiting: data %h", out_tdata);
        err_cnt++;
      end else begin
        exp_r = expected_reports.pop_front();
        if (exp_r.finished) n_finished++;
        if (exp_r.idle) n_idle++;
        check_field("idle", 32'(exp_r.idle), 32'(out_tdata[0]));
        check_field("running_id", 32'(exp_r.running_id), 32'(out_tdata[8:1]));
        check_field("finished", 32'(exp_r.finished), 32'(out_tdata[9]));
        check_field("turnaround", 32'(exp_r.turnaround), 32'(out_tdata[25:10]));
        check_field("waiting", 32'(exp_r.waiting), 32'(out_tdata[41:26]));
        check_field("all_done", 32'(exp_r.all_done), 32'(out_tdata[42]));
        check_field("padding", 0, 32'(out_tdata[47:43]));
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_req) begin
      stall_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (no_gaps) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 30);
    end
  end

  // An empty table reports idle with everything done.
  task automatic test_empty_table();
    send_ticks(2);
  endtask

  // A zero-burst entry never runs and leaves the table done.
  task automatic test_zero_burst();
    load_proc(8'hFF, 16'h0000, 16'h0000, 8'h00);
    send_ticks(1);
  endtask

  // Field extremes: this entry never arrives within the run.
  task automatic test_field_extremes();
    load_proc(8'h00, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_ticks(1);
  endtask

  // Preemption by a more urgent arrival, the running process keeping a tie,
  // and the lowest slot winning a tie when neither ran last.
  task automatic test_preemption();
    load_proc(8'h11, 16'h0000, 16'd6, 8'd10);
    load_proc(8'h22, sim_now + 16'd3, 16'd2, 8'd5);
    load_proc(8'h33, sim_now + 16'd1, 16'd2, 8'd10);
    send_ticks(12);
  endtask

  // Random ticks with loads spread out until the early slots are used.
  task automatic test_random_traffic(input int n_items);
    int loads_left;
    int a;
    logic [15:0] burst;
    logic [7:0]  prio;
    loads_left = EARLY_SLOTS - tbl_count;
    for (int i = 0; i < n_items; i++) begin
      no_gaps = (i >= 400 && i < 550);
      if (loads_left > 0 && $urandom_range(0, n_items - 1 - i) < loads_left) begin
        if ($urandom_range(0, 99) < 70) begin
          a = sim_now + $urandom_range(0, 60);
          if (a > 65535) a = 65535;
        end else begin
          a = $urandom_range(0, sim_now);
        end
        burst = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(1, 150)) :
                                               16'($urandom_range(1, 400));
        prio  = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 7)) :
                                               8'($urandom_range(0, 255));
        load_proc(8'($urandom_range(0, 255)), a[15:0], burst, prio);
        loads_left--;
      end else begin
        send_ticks(1);
      end
    end
    no_gaps = 1'b0;
  endtask

  // The receiver holds off while ticks keep coming, so the input stalls.
  task automatic test_backpressure();
    stall_req = 1'b1;
    send_ticks(30);
    wait_drained();
  endtask

  // A short early entry and one that never arrives,
  // then a full table that drops an urgent load.
  task automatic test_full_table();
    load_proc(8'hA5, 16'h0000, 16'd2, 8'd1);
    load_proc(8'h5A, 16'hFFFF, 16'd3, 8'd0);
    send_ticks(7);
    while (tbl_count < TABLE_DEPTH) begin
      load_proc(8'($urandom_range(0, 255)), 16'h0000, 16'($urandom_range(1, 4)), 8'd3);
    end
    load_proc(8'hEE, 16'h0000, 16'd4, 8'd0);
    send_ticks(12);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_zero_burst();
    test_field_extremes();
    test_preemption();
    test_random_traffic(1000);
    test_backpressure();
    test_full_table();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d loads and %0d ticks; checked %0d reports (%0d completions, %0d idle).",
             n_loads, n_ticks, n_reports, n_finished, n_idle);
    $display("Covered preemption, ties, zero burst, late arrivals, output stall, full table.");
    if (err_cnt == 0) begin
      $display("preemptive_priority_scheduler test passed");
    end else begin
      $display("preemptive_priority_scheduler test failed");
    end
    $finish;
  end

endmodule
